// ===== hdl/ntdc_pkg.sv =====
// shared types, character codes and helper functions for the number-to-digit-characters block
`default_nettype none

package ntdc_pkg;

    localparam int MAX_DIGITS = 16;

    localparam logic [1:0] KIND_UDEC = 2'd0;
    localparam logic [1:0] KIND_SDEC = 2'd1;
    localparam logic [1:0] KIND_HEX  = 2'd2;
    localparam logic [1:0] KIND_BIN  = 2'd3;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_A     = 7'h41;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_MINUS = 7'h2D;

    localparam logic [4:0] CONV_LAST_BIT = 5'd31;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    function automatic logic [4:0] clamp_count(input logic [1:0] k, input logic [4:0] c);
        logic [4:0] m;
        case (k)
            KIND_HEX: m = 5'd8;
            KIND_BIN: m = 5'd16;
            default:  m = 5'd10;
        endcase
        if (MAX_DIGITS < int'(m))
        begin
            m = 5'(MAX_DIGITS);
        end
        return (c > m) ? m : c;
    endfunction

    function automatic logic [6:0] glyph(input logic [3:0] d);
        logic [6:0] d7;
        d7 = {3'b000, d};
        return (d < 4'd10) ? (CH_ZERO + d7) : (CH_A + d7 - 7'd10);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/number_to_digit_chars.sv =====
// top level: serial binary-to-bcd conversion and character emission
//
//  beat     | valid      | stall      | payload
//  item in  | item_valid | item_stall | kind, number, digit_count, line, start_column
//  char out | char_valid | char_stall | char_code, line_out, column, last
//
// decimal modes run a shift-add-3 converter, one number bit per cycle, after the
// accept cycle, then emit their characters (sign included in signed decimal mode)
// hex and binary skip the converter and emit their characters after the accept cycle
// rst_n clears the state machine and the output valid flag at once
// a stalled output holds its character and pauses emission; no new item is
// taken until the last character of a run is in the output register
`default_nettype none

module number_to_digit_chars
    import ntdc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] number,
    input  wire logic [4:0]  digit_count,
    input  wire logic [2:0]  line,
    input  wire logic [4:0]  start_column,
    output logic             char_valid,
    input  wire logic        char_stall,
    output logic [6:0]       char_code,
    output logic [2:0]       line_out,
    output logic [5:0]       column,
    output logic             last
);

    state_t      state_reg, state_next;
    logic [1:0]  kind_reg;
    logic [4:0]  cnt_reg;
    logic [3:0]  pos_reg;
    logic [2:0]  line_reg;
    logic [5:0]  col_reg;
    logic        neg_reg;
    logic [31:0] bin_reg;
    logic [39:0] dig_reg;
    logic [39:0] dig_adj;
    logic [4:0]  bit_reg;
    logic        char_valid_reg;
    logic [6:0]  char_code_reg;
    logic [2:0]  line_out_reg;
    logic [5:0]  column_reg;
    logic        last_reg;

    logic        item_acc;
    logic        slot_free;
    logic        emit_sign;
    logic        emit_digit;
    logic        conv_step;
    logic        is_dec;
    logic [4:0]  cnt_in;
    logic [63:0] dig_wide;
    logic [3:0]  cur_digit;

    assign item_acc  = item_valid && !item_stall;
    assign slot_free = !char_valid_reg || !char_stall;
    assign is_dec    = (kind == KIND_UDEC) || (kind == KIND_SDEC);
    assign cnt_in    = clamp_count(kind, digit_count);
    assign dig_wide  = {24'h000000, dig_reg};

    // add 3 to every bcd digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < 10; i++)
        begin
            dig_adj[i*4 +: 4] = (dig_reg[i*4 +: 4] >= 4'd5) ?
                                (dig_reg[i*4 +: 4] + 4'd3) : dig_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        if (kind_reg == KIND_BIN)
        begin
            cur_digit = {3'b000, dig_reg[{2'b00, pos_reg}]};
        end
        else
        begin
            cur_digit = dig_wide[{pos_reg, 2'b00} +: 4];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    if (is_dec)
                    begin
                        state_next = ST_CONV;
                    end
                    else if (cnt_in != 5'd0)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_CONV:
            begin
                if (bit_reg == CONV_LAST_BIT)
                begin
                    if (kind_reg == KIND_SDEC)
                    begin
                        state_next = ST_SIGN;
                    end
                    else if (cnt_reg == 5'd0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    state_next = (cnt_reg == 5'd0) ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free && (pos_reg == 4'd0))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        item_stall = 1'b1;
        conv_step  = 1'b0;
        emit_sign  = 1'b0;
        emit_digit = 1'b0;
        case (state_reg)
            ST_IDLE: item_stall = 1'b0;
            ST_CONV: conv_step  = 1'b1;
            ST_SIGN: emit_sign  = slot_free;
            ST_EMIT: emit_digit = slot_free;
            default: item_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_sign || emit_digit)
            begin
                char_valid_reg <= 1'b1;
            end
            else if (!char_stall)
            begin
                char_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            kind_reg <= kind;
            cnt_reg  <= cnt_in;
            pos_reg  <= 4'(cnt_in - 5'd1);
            line_reg <= line;
            col_reg  <= {1'b0, start_column};
            neg_reg  <= number[31];
            bit_reg  <= 5'd0;
            if ((kind == KIND_SDEC) && number[31])
            begin
                bin_reg <= 32'd0 - number;
            end
            else
            begin
                bin_reg <= number;
            end
            dig_reg <= is_dec ? 40'd0 : {8'h00, number};
        end
        else if (conv_step)
        begin
            dig_reg <= {dig_adj[38:0], bin_reg[31]};
            bin_reg <= {bin_reg[30:0], 1'b0};
            bit_reg <= bit_reg + 5'd1;
        end
        else if (emit_sign)
        begin
            col_reg <= col_reg + 6'd1;
        end
        else if (emit_digit)
        begin
            col_reg <= col_reg + 6'd1;
            pos_reg <= pos_reg - 4'd1;
        end

        if (emit_sign)
        begin
            char_code_reg <= neg_reg ? CH_MINUS : CH_PLUS;
            line_out_reg  <= line_reg;
            column_reg    <= col_reg;
            last_reg      <= (cnt_reg == 5'd0);
        end
        else if (emit_digit)
        begin
            char_code_reg <= glyph(cur_digit);
            line_out_reg  <= line_reg;
            column_reg    <= col_reg;
            last_reg      <= (pos_reg == 4'd0);
        end
    end

    assign char_valid = char_valid_reg;
    assign char_code  = char_code_reg;
    assign line_out   = line_out_reg;
    assign column     = column_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    a_conv_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> ((kind_reg == KIND_UDEC) || (kind_reg == KIND_SDEC)))
        else $error("converter running for a non-decimal item");

    a_sign_signed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIGN) |-> (kind_reg == KIND_SDEC))
        else $error("sign emitted outside signed decimal mode");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ({1'b0, pos_reg} < cnt_reg))
        else $error("digit position beyond digit count");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_digit && (pos_reg == 4'd0)) |=> (state_reg == ST_IDLE))
        else $error("run did not end after final digit");
`endif

endmodule

`default_nettype wire
